/* rtl/core/lsde_pkg.sv */
// lsde_pkg: shared constants, types and helpers for the line sensor debounce block
// used by the channel interfaces, the debounce lanes, the side error units and the top level

package lsde_pkg;

  localparam int NumRoles = 8;
  localparam int NumSides = 4;
  localparam int RoleIdxW = $clog2(NumRoles);
  localparam int LimitW   = 8;
  localparam int CountW   = 9;
  localparam int ErrW     = 3;

  localparam logic [LimitW-1:0] LimitReset = 8'd3;
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

  // role order: fli flo fri fro bli blo bri bro
  localparam logic [RoleIdxW-1:0] RoleFli = 3'd0;
  localparam logic [RoleIdxW-1:0] RoleFlo = 3'd1;
  localparam logic [RoleIdxW-1:0] RoleFri = 3'd2;
  localparam logic [RoleIdxW-1:0] RoleFro = 3'd3;
  localparam logic [RoleIdxW-1:0] RoleBli = 3'd4;
  localparam logic [RoleIdxW-1:0] RoleBlo = 3'd5;
  localparam logic [RoleIdxW-1:0] RoleBri = 3'd6;
  localparam logic [RoleIdxW-1:0] RoleBro = 3'd7;

  // pin feeding each role when running in reverse (front and back rotated)
  localparam logic [RoleIdxW-1:0] ReversePin [NumRoles] =
    '{3'd6, 3'd7, 3'd4, 3'd5, 3'd2, 3'd3, 3'd0, 3'd1};

  // side error codes
  localparam logic signed [ErrW-1:0] ErrNeg2 = -3'sd2;
  localparam logic signed [ErrW-1:0] ErrNeg1 = -3'sd1;
  localparam logic signed [ErrW-1:0] ErrZero = 3'sd0;
  localparam logic signed [ErrW-1:0] ErrPos1 = 3'sd1;
  localparam logic signed [ErrW-1:0] ErrPos2 = 3'sd2;

  // debounced sensor pair of one side: dominant and other sensor
  typedef struct packed {
    logic dom;
    logic oth;
  } side_pair_t;

  // per-beat control from the top level to the state holding units
  typedef struct packed {
    logic take;
    logic clear;
  } beat_ctrl_t;

  // position error from the pair and the previous error of that side
  function automatic logic signed [ErrW-1:0] side_error(input side_pair_t pair,
                                                        input logic signed [ErrW-1:0] last);
    logic signed [ErrW-1:0] err;
    if (pair.dom && pair.oth) begin
      err = ErrZero;
    end else if (!pair.dom) begin
      if ((last > ErrZero) && !pair.oth) begin
        err = ErrPos2;
      end else if (last < ErrZero) begin
        err = ErrNeg2;
      end else begin
        err = ErrPos1;
      end
    end else begin
      err = ErrNeg1;
    end
    return err;
  endfunction

endpackage

/* rtl/core/lsde_if.sv */
// lsde_in_if / lsde_out_if: valid-ready channels of the line sensor debounce block
// depends on lsde_pkg for the error width and the role count

interface lsde_in_if;
  logic valid;
  logic ready;
  logic pin_front_left_inner;
  logic pin_front_left_outer;
  logic pin_front_right_inner;
  logic pin_front_right_outer;
  logic pin_back_left_inner;
  logic pin_back_left_outer;
  logic pin_back_right_inner;
  logic pin_back_right_outer;
  logic forward;

  modport source (
    output valid, pin_front_left_inner, pin_front_left_outer, pin_front_right_inner,
           pin_front_right_outer, pin_back_left_inner, pin_back_left_outer,
           pin_back_right_inner, pin_back_right_outer, forward,
    input  ready
  );

  modport sink (
    input  valid, pin_front_left_inner, pin_front_left_outer, pin_front_right_inner,
           pin_front_right_outer, pin_back_left_inner, pin_back_left_outer,
           pin_back_right_inner, pin_back_right_outer, forward,
    output ready
  );
endinterface

interface lsde_out_if;
  logic valid;
  logic ready;
  logic signed [lsde_pkg::ErrW-1:0] front_left_error;
  logic signed [lsde_pkg::ErrW-1:0] front_right_error;
  logic signed [lsde_pkg::ErrW-1:0] back_left_error;
  logic signed [lsde_pkg::ErrW-1:0] back_right_error;
  logic [lsde_pkg::NumRoles-1:0]    debounced_levels;
  logic front_all_off;
  logic back_all_off;

  modport source (
    output valid, front_left_error, front_right_error, back_left_error, back_right_error,
           debounced_levels, front_all_off, back_all_off,
    input  ready
  );

  modport sink (
    input  valid, front_left_error, front_right_error, back_left_error, back_right_error,
           debounced_levels, front_all_off, back_all_off,
    output ready
  );
endinterface

/* rtl/core/line_sensor_debounce_error.sv */
// line_sensor_debounce_error: top level with eight debounce lanes and four side units
// depends on lsde_pkg, lsde_in_if, lsde_out_if, lsde_lane and lsde_side
//
// Usage:
//   in_i carries one beat per sensor tick: eight raw pins and the forward flag.
//   out_o carries one beat per input beat: four side errors (back ones negated),
//   the debounced role levels and the raw all-off flags of front and back.
//   cfg_we_i/cfg_data_i write debounce_limit (reset value 3); write only while idle.
// Registering and throughput:
//   an accepted input beat is captured in the output register; one beat per cycle
//   sustained while out_o.ready is high, set by the single output register that the
//   eight lanes and the four side units feed in parallel.
// Reset:
//   rst_ni clears all lane and side state, selects forward direction, empties the
//   output register and loads the default limit; in_i.ready is high right after.
// Stall:
//   while out_o.ready is low a held result keeps its value and in_i.ready drops;
//   a new beat is taken in the same cycle the held one leaves.

module line_sensor_debounce_error (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lsde_in_if.sink                      in_i,
  lsde_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [lsde_pkg::LimitW-1:0]  cfg_data_i
);
  import lsde_pkg::*;

  logic [LimitW-1:0]      limit_q;
  logic                   dir_q;
  logic                   out_valid_q;
  logic                   take;
  beat_ctrl_t             ctrl;
  logic [NumRoles-1:0]    pins;
  logic [NumRoles-1:0]    raw;
  logic [NumRoles-1:0]    levels;
  side_pair_t             pair [NumSides];
  logic signed [ErrW-1:0] err  [NumSides];

  logic signed [ErrW-1:0] fl_err_q, fr_err_q, bl_err_q, br_err_q;
  logic [NumRoles-1:0]    levels_q;
  logic                   front_off_q, back_off_q;

  // handshake: accept whenever the output register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign ctrl.take  = take;
  assign ctrl.clear = (in_i.forward != dir_q);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // direction tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b1;
    end else if (take) begin
      dir_q <= in_i.forward;
    end
  end

  // pins in role order, then rotated for reverse travel
  assign pins = {in_i.pin_back_right_outer, in_i.pin_back_right_inner,
                 in_i.pin_back_left_outer,  in_i.pin_back_left_inner,
                 in_i.pin_front_right_outer, in_i.pin_front_right_inner,
                 in_i.pin_front_left_outer,  in_i.pin_front_left_inner};

  always_comb begin
    for (int i = 0; i < NumRoles; i++) begin
      raw[i] = in_i.forward ? pins[i] : pins[ReversePin[i]];
    end
  end

  // debounce lanes, one per role
  for (genvar g = 0; g < NumRoles; g++) begin : g_lane
    lsde_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .raw_i   (raw[g]),
      .limit_i (limit_q),
      .level_o (levels[g])
    );
  end

  // merge lanes into side pairs: left uses inner as dominant, right uses outer
  assign pair[0] = '{dom: levels[RoleFli], oth: levels[RoleFlo]};
  assign pair[1] = '{dom: levels[RoleFro], oth: levels[RoleFri]};
  assign pair[2] = '{dom: levels[RoleBli], oth: levels[RoleBlo]};
  assign pair[3] = '{dom: levels[RoleBro], oth: levels[RoleBri]};

  for (genvar s = 0; s < NumSides; s++) begin : g_side
    lsde_side u_side (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pair_i (pair[s]),
      .err_o  (err[s])
    );
  end

  // output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      fl_err_q    <= err[0];
      fr_err_q    <= err[1];
      bl_err_q    <= -err[2];
      br_err_q    <= -err[3];
      levels_q    <= levels;
      front_off_q <= ~|raw[RoleFro:RoleFli];
      back_off_q  <= ~|raw[RoleBro:RoleBli];
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.front_left_error  = fl_err_q;
  assign out_o.front_right_error = fr_err_q;
  assign out_o.back_left_error   = bl_err_q;
  assign out_o.back_right_error  = br_err_q;
  assign out_o.debounced_levels  = levels_q;
  assign out_o.front_all_off     = front_off_q;
  assign out_o.back_all_off      = back_off_q;

  // an accepted beat always yields a result in the next cycle
  a_take_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q)
    else $error("accepted beat produced no result");

  // a held result never blocks when the register is empty
  a_empty_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");

  // the front left and back right side errors never take the values -3 or -4
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fl_err_q != -3'sd3) && (fl_err_q != -3'sd4) &&
                    (br_err_q != -3'sd3) && (br_err_q != -3'sd4))
    else $error("side error out of range");

  // direction only moves on an accepted beat
  a_dir_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(dir_q))
    else $error("direction changed without a beat");

endmodule

/* rtl/core/lsde_lane.sv */
// lsde_lane: debounce of one sensor role channel
// depends on lsde_pkg for widths and the beat control struct

module lsde_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lsde_pkg::beat_ctrl_t        ctrl_i,
  input  logic                        raw_i,
  input  logic [lsde_pkg::LimitW-1:0] limit_i,
  output logic                        level_o
);
  import lsde_pkg::*;

  logic              level_q, level_d;
  logic              prev_q;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;

  // count a level that is steady and differs from the accepted one
  always_comb begin
    count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
    level_d   = level_q;
    count_d   = '0;
    if ((raw_i == prev_q) && (raw_i != level_q)) begin
      count_d = count_inc;
      if (count_inc > {1'b0, limit_i}) begin
        level_d = raw_i;
      end
    end
  end

  assign level_o = level_d;

  // lane state advances once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      prev_q  <= 1'b0;
      count_q <= '0;
    end else if (ctrl_i.take) begin
      level_q <= level_d;
      prev_q  <= raw_i;
      count_q <= count_d;
    end
  end

endmodule

/* rtl/core/lsde_side.sv */
// lsde_side: position error of one side pair with its remembered last error
// depends on lsde_pkg for the side_error function and the struct types

module lsde_side (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lsde_pkg::beat_ctrl_t              ctrl_i,
  input  lsde_pkg::side_pair_t              pair_i,
  output logic signed [lsde_pkg::ErrW-1:0]  err_o
);
  import lsde_pkg::*;

  logic signed [ErrW-1:0] last_q;
  logic signed [ErrW-1:0] last_eff;

  // a direction change forgets the history before this beat is scored
  assign last_eff = ctrl_i.clear ? ErrZero : last_q;
  assign err_o    = side_error(pair_i, last_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= ErrZero;
    end else if (ctrl_i.take) begin
      last_q <= err_o;
    end
  end

endmodule

/* verif/tb_line_sensor_debounce_error.sv */
// testbench for line_sensor_debounce_error: random sensor ticks, debounce limits and stalls
// predicts each output beat and checks it field by field against the block
// depends on lsde_pkg, lsde_in_if, lsde_out_if and the rtl of the block

module tb_line_sensor_debounce_error;
  import lsde_pkg::*;

  localparam int LongHoldOff = 60;

  // one sensor tick: pins in role order fli flo fri fro bli blo bri bro
  typedef struct packed {
    logic                fwd;
    logic [NumRoles-1:0] pins;
  } sensor_tick_t;

  // one result beat
  typedef struct packed {
    logic signed [ErrW-1:0] fl;
    logic signed [ErrW-1:0] fr;
    logic signed [ErrW-1:0] bl;
    logic signed [ErrW-1:0] br;
    logic [NumRoles-1:0]    levels;
    logic                   front_off;
    logic                   back_off;
  } line_result_t;

  // tracks debounce and side error state, holds the expected result beats
  class line_error_tracker;
    logic [LimitW-1:0]      limit_val;
    logic                   dir;
    logic [NumRoles-1:0]    accepted;
    logic [NumRoles-1:0]    prev_raw;
    logic [CountW-1:0]      stable_cnt [NumRoles];
    logic signed [ErrW-1:0] last_fl, last_fr, last_bl, last_br;
    line_result_t           expected_q [$];
    int                     mismatches;

    function new();
      limit_val  = LimitReset;
      dir        = 1'b1;
      accepted   = '0;
      prev_raw   = '0;
      foreach (stable_cnt[i]) stable_cnt[i] = '0;
      last_fl    = ErrZero;
      last_fr    = ErrZero;
      last_bl    = ErrZero;
      last_br    = ErrZero;
      mismatches = 0;
    endfunction

    // position error of one side from dominant and other sensor
    function logic signed [ErrW-1:0] pair_error(logic dom, logic oth,
                                                logic signed [ErrW-1:0] prior);
      if (dom && oth) return ErrZero;
      if (dom) return ErrNeg1;
      if ((prior > ErrZero) && !oth) return ErrPos2;
      if (prior < ErrZero) return ErrNeg2;
      return ErrPos1;
    endfunction

    function void take_tick(sensor_tick_t t);
      logic [NumRoles-1:0] raw;
      line_result_t        r;
      // direction change wipes the error history only
      if (t.fwd != dir) begin
        last_fl = ErrZero;
        last_fr = ErrZero;
        last_bl = ErrZero;
        last_br = ErrZero;
        dir     = t.fwd;
      end
      // role mapping, front and back rotated in reverse
      for (int i = 0; i < NumRoles; i++) begin
        raw[i] = t.fwd ? t.pins[i] : t.pins[ReversePin[i]];
      end
      // per role debounce
      for (int i = 0; i < NumRoles; i++) begin
        if (raw[i] == prev_raw[i] && raw[i] != accepted[i]) begin
          if (stable_cnt[i] != CountMax) stable_cnt[i] = stable_cnt[i] + 1'b1;
          if (stable_cnt[i] > limit_val) accepted[i] = raw[i];
        end else begin
          stable_cnt[i] = '0;
        end
        prev_raw[i] = raw[i];
      end
      // side errors, left pairs inner dominant, right pairs outer dominant
      last_fl = pair_error(accepted[RoleFli], accepted[RoleFlo], last_fl);
      last_fr = pair_error(accepted[RoleFro], accepted[RoleFri], last_fr);
      last_bl = pair_error(accepted[RoleBli], accepted[RoleBlo], last_bl);
      last_br = pair_error(accepted[RoleBro], accepted[RoleBri], last_br);
      r.fl        = last_fl;
      r.fr        = last_fr;
      r.bl        = -last_bl;
      r.br        = -last_br;
      r.levels    = accepted;
      r.front_off = ~|raw[RoleFro:RoleFli];
      r.back_off  = ~|raw[RoleBro:RoleBli];
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic signed [8:0] want, logic signed [8:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
      end
    endfunction

    function void compare_result(line_result_t got);
      line_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with no expectation pending");
        return;
      end
      want = expected_q.pop_front();
      check_field("front_left_error", want.fl, got.fl);
      check_field("front_right_error", want.fr, got.fr);
      check_field("back_left_error", want.bl, got.bl);
      check_field("back_right_error", want.br, got.br);
      check_field("debounced_levels", want.levels, got.levels);
      check_field("front_all_off", want.front_off, got.front_off);
      check_field("back_all_off", want.back_off, got.back_off);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_data_i;

  lsde_in_if  in_if ();
  lsde_out_if out_if ();

  line_error_tracker tracker;
  int                send_burst;
  int                recv_burst;
  bit                hold_off_req;
  logic              run_fwd;

  line_sensor_debounce_error uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // idle cycles before a beat, with stretches of back to back beats
  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // offer one tick and wait until it is accepted
  task automatic send_tick(sensor_tick_t t);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid                 <= 1'b1;
    in_if.pin_front_left_inner  <= t.pins[RoleFli];
    in_if.pin_front_left_outer  <= t.pins[RoleFlo];
    in_if.pin_front_right_inner <= t.pins[RoleFri];
    in_if.pin_front_right_outer <= t.pins[RoleFro];
    in_if.pin_back_left_inner   <= t.pins[RoleBli];
    in_if.pin_back_left_outer   <= t.pins[RoleBlo];
    in_if.pin_back_right_inner  <= t.pins[RoleBri];
    in_if.pin_back_right_outer  <= t.pins[RoleBro];
    in_if.forward               <= t.fwd;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.take_tick(t);
  endtask

  task automatic send_held(logic [NumRoles-1:0] pins, logic fwd, int n);
    sensor_tick_t t;
    t.pins = pins;
    t.fwd  = fwd;
    repeat (n) send_tick(t);
  endtask

  // held patterns with random content, glitches and direction flips
  task automatic run_random(int n);
    int                  sent;
    int                  span;
    int                  len;
    logic [NumRoles-1:0] pat;
    sensor_tick_t        t;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) run_fwd = ~run_fwd;
      pat  = NumRoles'($urandom);
      span = (tracker.limit_val < 36) ? tracker.limit_val + 4 : 12;
      len  = $urandom_range(1, span);
      repeat (len) begin
        t.fwd  = run_fwd;
        t.pins = pat;
        if ($urandom_range(0, 11) == 0) begin
          t.pins[RoleIdxW'($urandom_range(0, NumRoles-1))] ^= 1'b1;
        end
        send_tick(t);
        sent++;
      end
    end
  endtask

  // stop offering and wait until every expected beat is back
  task automatic finish_phase();
    in_if.valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.limit_val = v;
  endtask

  // result side: random ready, one long hold-off on request
  initial begin
    int           gap;
    line_result_t got;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = LongHoldOff;
      end else begin
        gap = draw_gap(recv_burst);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got.fl        = out_if.front_left_error;
      got.fr        = out_if.front_right_error;
      got.bl        = out_if.back_left_error;
      got.br        = out_if.back_right_error;
      got.levels    = out_if.debounced_levels;
      got.front_off = out_if.front_all_off;
      got.back_off  = out_if.back_all_off;
      tracker.compare_result(got);
    end
  end

  // stimulus
  initial begin
    int failures;
    tracker      = new();
    send_burst   = 0;
    recv_burst   = 0;
    hold_off_req = 1'b0;
    run_fwd      = 1'b1;
    rst_ni                      <= 1'b0;
    cfg_we_i                    <= 1'b0;
    cfg_data_i                  <= '0;
    in_if.valid                 <= 1'b0;
    in_if.pin_front_left_inner  <= 1'b0;
    in_if.pin_front_left_outer  <= 1'b0;
    in_if.pin_front_right_inner <= 1'b0;
    in_if.pin_front_right_outer <= 1'b0;
    in_if.pin_back_left_inner   <= 1'b0;
    in_if.pin_back_left_outer   <= 1'b0;
    in_if.pin_back_right_inner  <= 1'b0;
    in_if.pin_back_right_outer  <= 1'b0;
    in_if.forward               <= 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default limit: all off, then all on held long enough to be accepted
    send_held(8'h00, 1'b1, 1);
    send_held(8'hFF, 1'b1, 5);
    finish_phase();

    // limit zero: side error walk through every case, a glitch, reverse mapping
    write_limit(8'd0);
    send_held(8'hAA, 1'b1, 2);
    send_held(8'h00, 1'b1, 2);
    send_held(8'h55, 1'b1, 2);
    send_held(8'h00, 1'b1, 2);
    send_held(8'hFF, 1'b1, 1);
    send_held(8'h00, 1'b1, 1);
    send_held(8'h0F, 1'b0, 2);
    send_held(8'hF0, 1'b0, 2);
    send_held(8'h3C, 1'b1, 2);
    run_random(200);
    finish_phase();

    // limit one with the output held off so the input stalls
    write_limit(8'd1);
    hold_off_req = 1'b1;
    run_random(200);
    finish_phase();

    write_limit(8'd2);
    run_random(200);
    finish_phase();

    // largest limit: levels change only after long stable stretches
    write_limit(8'd255);
    send_held(8'h00, 1'b1, 260);
    send_held(8'hFF, 1'b1, 260);
    run_random(60);
    finish_phase();

    write_limit(LimitW'($urandom_range(4, 20)));
    run_random(200);
    finish_phase();

    // back to the reset value, another long hold-off
    write_limit(LimitReset);
    hold_off_req = 1'b1;
    run_random(150);
    finish_phase();

    repeat (4) @(posedge clk_i);
    failures = tracker.mismatches + tracker.expected_q.size();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* line_sensor_debounce_error.f */
rtl/core/lsde_pkg.sv
rtl/core/lsde_if.sv
rtl/core/lsde_lane.sv
rtl/core/lsde_side.sv
rtl/core/line_sensor_debounce_error.sv
verif/tb_line_sensor_debounce_error.sv
